// File: rtl/grayscale_sobel_edge_stream_macros.svh
// Assertion macros for the grayscale / Sobel edge stream.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef GRAYSCALE_SOBEL_EDGE_STREAM_MACROS_SVH
`define GRAYSCALE_SOBEL_EDGE_STREAM_MACROS_SVH

// same-cycle implication, masked during reset
`define GSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define GSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gse_pkg.sv
// Shared types and constants for the grayscale / Sobel edge stream.
// No dependencies.
`timescale 1ns / 1ps

package gse_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CMP_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CFG_IDX_W = 1;

    // Q0.16 luma weights
    localparam logic [15:0] W_CHAN0 = 16'd13933;
    localparam logic [15:0] W_CHAN1 = 16'd46871;
    localparam logic [15:0] W_CHAN2 = 16'd4732;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [COL_W-1:0]     t_col;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);

    // one line-buffer entry: gray of row-2 and row-1 at a column
    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_line_word;

    typedef struct packed {
        logic rd_en;
        t_col rd_addr;
        logic wr_en;
        t_col wr_addr;
    } t_line_ctl;

    // one window column, top to bottom
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_wcol;

endpackage

// File: rtl/gse_pix_if.sv
// Pixel input channel: valid/ready with three color channels.
// Depends on gse_pkg.
`timescale 1ns / 1ps

interface gse_pix_if;
    import gse_pkg::*;

    logic valid;
    logic ready;
    t_pix chan0;
    t_pix chan1;
    t_pix chan2;

    modport source(output valid, output chan0, output chan1, output chan2, input ready);
    modport sink(input valid, input chan0, input chan1, input chan2, output ready);
endinterface

// File: rtl/gse_res_if.sv
// Result channel: valid/ready with gray, edge magnitude and flags.
// Depends on gse_pkg.
`timescale 1ns / 1ps

interface gse_res_if;
    import gse_pkg::*;

    logic valid;
    logic ready;
    t_pix gray;
    t_pix edge_res;
    logic edge_valid;
    logic frame_last;

    modport source(output valid, output gray, output edge_res, output edge_valid,
                   output frame_last, input ready);
    modport sink(input valid, input gray, input edge_res, input edge_valid,
                 input frame_last, output ready);
endinterface

// File: rtl/grayscale_sobel_edge_stream.sv
// Top level: pixel counters, input stage, line buffer, Sobel and result register.
// Depends on gse_pkg, gse_pix_if, gse_res_if, gse_gray, gse_line_buf, gse_sobel.
//
//  channel  | dir | transfer when        | payload
//  ---------+-----+----------------------+------------------------------------
//  i_pix    | in  | valid & ready        | chan0, chan1, chan2 (8 bit each)
//  o_res    | out | valid & ready        | gray, edge_res, edge_valid, frame_last
//  i_cfg_*  | in  | i_cfg_we             | idx 0 frame_width, 1 frame_height
//
// One pixel per clock sustained while o_res is not stalled; a transfer passes stage 1, then the result register.
// Stage 1 holds the pixel and the line-buffer read issued at its transfer; gray,
// window and Sobel sit between stage 1 and the result register.
// A stalled result holds stage 1; a new pixel still enters while stage 1 moves on.
// Synchronous active-low reset clears counters and valids and sets config to 640 x 480.
`timescale 1ns / 1ps

module grayscale_sobel_edge_stream (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gse_pix_if.sink               i_pix,
    gse_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  gse_pkg::t_cfg_idx     i_cfg_idx,
    input  gse_pkg::t_cfg         i_cfg_data
);
    import gse_pkg::*;

    t_cfg r_frame_width;
    t_cfg r_frame_height;

    t_col r_col;
    t_row r_row;

    logic r_s1_valid;
    t_pix r_s1_chan0;
    t_pix r_s1_chan1;
    t_pix r_s1_chan2;
    t_col r_s1_col;
    logic r_s1_interior;
    logic r_s1_last;

    logic r_out_valid;
    t_pix r_out_gray;
    t_pix r_out_edge;
    logic r_out_edge_valid;
    logic r_out_last;

    logic       w_in_xfer;
    logic       w_adv;
    logic       w_last_col;
    logic       w_last_row;
    logic       w_interior;
    t_col       n_col;
    t_row       n_row;
    t_pix       w_gray;
    t_pix       w_edge;
    t_line_ctl  w_line_ctl;
    t_line_word w_line_rd;
    t_line_word w_line_wr;
    t_wcol      w_col_new;

    // ---- handshake ----
    assign w_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || w_adv;
    assign w_in_xfer   = i_pix.valid && i_pix.ready;

    // ---- config ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- raster position ----
    // width clamped to 3..MAX_WIDTH, height raised to 3
    always_comb begin
        w_last_col = ((CMP_W'(r_col) + CMP_W'(1) >= CMP_W'(r_frame_width))
                      && (r_col >= COL_W'(2)))
                  || (r_col == COL_W'(MAX_WIDTH - 1));
        w_last_row = ((13'(r_row) + 13'd1 >= 13'(r_frame_height))
                      && (r_row >= ROW_W'(2)));
        w_interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_xfer) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_chan0    <= i_pix.chan0;
            r_s1_chan1    <= i_pix.chan1;
            r_s1_chan2    <= i_pix.chan2;
            r_s1_col      <= r_col;
            r_s1_interior <= w_interior;
            r_s1_last     <= w_last_col && w_last_row;
        end
    end

    // read for the entering pixel, write-back for the pixel leaving stage 1
    always_comb begin
        w_line_ctl.rd_en   = w_in_xfer;
        w_line_ctl.rd_addr = r_col;
        w_line_ctl.wr_en   = w_adv;
        w_line_ctl.wr_addr = r_s1_col;
        w_line_wr.upper    = w_line_rd.lower;
        w_line_wr.lower    = w_gray;
        w_col_new.top      = w_line_rd.upper;
        w_col_new.mid      = w_line_rd.lower;
        w_col_new.bot      = w_gray;
    end

    gse_gray u_gray (
        .i_chan0 (r_s1_chan0),
        .i_chan1 (r_s1_chan1),
        .i_chan2 (r_s1_chan2),
        .o_gray  (w_gray)
    );

    gse_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_ctl     (w_line_ctl),
        .i_wr_data (w_line_wr),
        .o_rd_data (w_line_rd)
    );

    gse_sobel u_sobel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_interior (r_s1_interior),
        .i_col_new  (w_col_new),
        .o_edge     (w_edge)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_gray       <= w_gray;
            r_out_edge       <= w_edge;
            r_out_edge_valid <= r_s1_interior;
            r_out_last       <= r_s1_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.gray       = r_out_gray;
    assign o_res.edge_res   = r_out_edge;
    assign o_res.edge_valid = r_out_edge_valid;
    assign o_res.frame_last = r_out_last;

    // ---- checks ----
    `include "grayscale_sobel_edge_stream_macros.svh"

    `GSE_ASSERT_NOW(a_line_no_collide, w_line_ctl.rd_en && w_line_ctl.wr_en, w_line_ctl.rd_addr != w_line_ctl.wr_addr, "line buffer read and write hit the same column")
    `GSE_ASSERT_NEXT(a_frame_wrap, w_in_xfer && w_last_col && w_last_row, r_col == '0 && r_row == '0, "raster counters did not wrap after the last pixel")
    `GSE_ASSERT_NEXT(a_s1_hold, r_s1_valid && r_out_valid && !o_res.ready, r_s1_valid && $stable(r_s1_col) && $stable(r_s1_chan1), "stage 1 changed while the result was stalled")
    `GSE_ASSERT_NOW(a_border_zero, r_out_valid && !r_out_edge_valid, r_out_edge == '0, "border pixel carries a nonzero edge value")

endmodule

// File: rtl/gse_gray.sv
// Luma conversion: Q0.16 weighted sum of three channels, floored.
// Depends on gse_pkg.
`timescale 1ns / 1ps

module gse_gray (
    input  gse_pkg::t_pix i_chan0,
    input  gse_pkg::t_pix i_chan1,
    input  gse_pkg::t_pix i_chan2,
    output gse_pkg::t_pix o_gray
);
    import gse_pkg::*;

    // max sum is 255 * 65536, fits 24 bits
    logic [23:0] w_sum;

    always_comb begin
        w_sum = 24'(i_chan0) * 24'(W_CHAN0)
              + 24'(i_chan1) * 24'(W_CHAN1)
              + 24'(i_chan2) * 24'(W_CHAN2);
    end

    assign o_gray = w_sum[23:16];
endmodule

// File: rtl/gse_line_buf.sv
// Two gray lines packed in one memory word, one write and one read port.
// Read data is registered; depends on gse_pkg.
`timescale 1ns / 1ps

module gse_line_buf (
    input  logic                  i_clk,
    input  gse_pkg::t_line_ctl    i_ctl,
    input  gse_pkg::t_line_word   i_wr_data,
    output gse_pkg::t_line_word   o_rd_data
);
    import gse_pkg::*;

    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/gse_sobel.sv
// 3x3 window (two stored columns plus the incoming one) and Sobel |Gx|+|Gy|.
// Depends on gse_pkg.
`timescale 1ns / 1ps

module gse_sobel (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_interior,
    input  gse_pkg::t_wcol i_col_new,
    output gse_pkg::t_pix  o_edge
);
    import gse_pkg::*;

    localparam int SUM_W = PIX_W + 3;

    t_wcol r_near;   // column col-1
    t_wcol r_far;    // column col-2

    logic signed [SUM_W-1:0] w_gx;
    logic signed [SUM_W-1:0] w_gy;
    logic        [SUM_W-1:0] w_abs_gx;
    logic        [SUM_W-1:0] w_abs_gy;
    logic        [SUM_W-1:0] w_mag;

    function automatic logic signed [SUM_W-1:0] ext(input t_pix v);
        return $signed({3'b000, v});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '0;
            r_far  <= '0;
        end else if (i_adv) begin
            r_far  <= r_near;
            r_near <= i_col_new;
        end
    end

    always_comb begin
        w_gx = (ext(i_col_new.top) - ext(r_far.top))
             + ((ext(i_col_new.mid) - ext(r_far.mid)) <<< 1)
             + (ext(i_col_new.bot) - ext(r_far.bot));
        w_gy = (ext(r_far.top) + (ext(r_near.top) <<< 1) + ext(i_col_new.top))
             - (ext(r_far.bot) + (ext(r_near.bot) <<< 1) + ext(i_col_new.bot));
        w_abs_gx = w_gx[SUM_W-1] ? SUM_W'(-w_gx) : SUM_W'(w_gx);
        w_abs_gy = w_gy[SUM_W-1] ? SUM_W'(-w_gy) : SUM_W'(w_gy);
        w_mag    = w_abs_gx + w_abs_gy;
        if (!i_interior) begin
            o_edge = '0;
        end else if (w_mag > SUM_W'(255)) begin
            o_edge = '1;
        end else begin
            o_edge = w_mag[PIX_W-1:0];
        end
    end
endmodule
